>>> hw/rtl/adapter_reply_deframer_defines.svh
// Assertion macros shared by the reply deframer RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ADAPTER_REPLY_DEFRAMER_DEFINES_SVH
`define ADAPTER_REPLY_DEFRAMER_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define ARD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ARD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ARD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ard_pkg.sv
// Shared types and constants for the adapter reply deframer.
// No dependencies.
package ard_pkg;

  // Default message buffer depth in bytes
  localparam int MSG_BYTES_DEF = 64;

  // Header and channel characters
  localparam logic [7:0] CHR_A      = 8'h61;  // 'a'
  localparam logic [7:0] CHR_R      = 8'h72;  // 'r'
  localparam logic [7:0] CHR_STATUS = 8'h6F;  // 'o'
  localparam logic [7:0] CHR_ERROR  = 8'h65;  // 'e'
  localparam logic [7:0] CHR_DATA   = 8'h33;  // '3'

  // Record type handling: bit 1 is ignored
  localparam logic [7:0] KIND_MASK  = 8'hFD;
  localparam logic [7:0] KIND_DATA  = 8'h00;
  localparam logic [7:0] KIND_END0  = 8'h40;
  localparam logic [7:0] KIND_END1  = 8'h44;

  // Parser phase
  typedef enum logic [2:0] {
    PH_A,
    PH_R,
    PH_CHAN,
    PH_LEN,
    PH_BODY,
    PH_STATUS
  } ph_t;

  // Readout sequencer state
  typedef enum logic {
    EM_IDLE,
    EM_RUN
  } em_state_t;

  // Parser to buffer control
  typedef struct packed {
    logic wr_en;    // store one payload byte
    logic emit_go;  // start reading the message out
  } ard_ctl_t;

endpackage

>>> hw/rtl/ard_stream_if.sv
// Valid/ready stream interfaces for the reply deframer.
// No dependencies.
interface ard_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_transfer;

  modport source (output valid, rx_byte, end_of_transfer, input ready);
  modport sink   (input valid, rx_byte, end_of_transfer, output ready);
endinterface

interface ard_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       last_byte;
  logic       checksum_good;

  modport source (output valid, msg_byte, last_byte, checksum_good, input ready);
  modport sink   (input valid, msg_byte, last_byte, checksum_good, output ready);
endinterface

>>> hw/rtl/ard_msg_buf.sv
// Message byte store and readout sequencer with checksum check.
// Depends on ard_pkg, ard_stream_if and the assertion macro header.
`include "adapter_reply_deframer_defines.svh"

module ard_msg_buf
  import ard_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF,
  parameter int AW        = $clog2(MSG_BYTES),
  parameter int CW        = $clog2(MSG_BYTES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ard_ctl_t        ctl,
  input  logic [AW-1:0]   wr_addr,
  input  logic [7:0]      wr_data,
  input  logic [CW-1:0]   emit_len,
  output logic            busy,
  ard_msg_if.source       out_ch
);

  logic [7:0]    mem [MSG_BYTES];
  logic [7:0]    q_r;
  em_state_t     state_r, state_nxt;
  logic [CW-1:0] rd_idx_r;
  logic [CW-1:0] len_r;
  logic          multi_r;
  logic          last_r;
  logic          ov_r;
  logic [7:0]    sum_r;
  logic          out_take;
  logic          rd_en;
  logic          slot_free;

  assign out_take  = ov_r && out_ch.ready;
  assign slot_free = !ov_r || out_take;
  assign rd_en     = (state_r == EM_RUN) && (rd_idx_r != len_r) && slot_free;
  assign busy      = (state_r == EM_RUN);

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: begin
        if (ctl.emit_go) state_nxt = EM_RUN;
      end
      EM_RUN: begin
        if ((rd_idx_r == len_r) && slot_free) state_nxt = EM_IDLE;
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (rd_en) begin
        ov_r <= 1'b1;
      end else if (out_take) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Readout counters and running sum of bytes already delivered
  always_ff @(posedge clk) begin
    if (ctl.emit_go) begin
      rd_idx_r <= '0;
      len_r    <= emit_len;
      multi_r  <= (emit_len >= CW'(2));
      sum_r    <= 8'h00;
    end else begin
      if (rd_en) begin
        rd_idx_r <= rd_idx_r + CW'(1);
        last_r   <= (({1'b0, rd_idx_r} + (CW+1)'(1)) == {1'b0, len_r});
      end
      if (out_take) sum_r <= sum_r + q_r;
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) q_r <= mem[rd_idx_r[AW-1:0]];
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.msg_byte      = q_r;
  assign out_ch.last_byte     = last_r;
  assign out_ch.checksum_good = last_r && multi_r && (sum_r == q_r);

  `ARD_ASSERT_IMP(a_go_when_idle, ctl.emit_go, state_r == EM_IDLE, "emit start while busy")
  `ARD_ASSERT_IMP(a_no_wr_in_run, ctl.wr_en, state_r == EM_IDLE, "store write during readout")
  `ARD_ASSERT_IMP(a_valid_in_run, ov_r, state_r == EM_RUN, "output valid outside readout")
  `ARD_ASSERT_IMP(a_idx_bound, state_r == EM_RUN, rd_idx_r <= len_r, "read index past length")

endmodule

>>> hw/rtl/adapter_reply_deframer.sv
// Top level of the adapter reply deframer: record parser plus message buffer.
// Depends on ard_pkg, ard_stream_if, ard_msg_buf and the assertion macro header.
//
// Parses 'a','r',channel,length,body records from the adapter reply stream and
// reassembles the ECU message from type 0x00 payloads into an on-chip byte
// buffer of MSG_BYTES entries. One input byte is taken per clock while parsing.
// When an end record (type 0x40/0x44) completes with a message held, input is
// held off while the N stored bytes stream out, one per cycle through the
// buffer's single read port when the output sink does not stall. The buffer
// needs no clearing pass after reset: only written bytes are ever read.
`include "adapter_reply_deframer_defines.svh"

module adapter_reply_deframer
  import ard_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ard_rx_if.sink     in_ch,
  ard_msg_if.source  out_ch
);

  localparam int AW = $clog2(MSG_BYTES);
  localparam int CW = $clog2(MSG_BYTES + 1);
  localparam int SW = ((CW > 8) ? CW : 8) + 1;
  localparam logic [CW-1:0] MSG_C = CW'(MSG_BYTES);
  localparam logic [SW-1:0] MSG_S = SW'(MSG_BYTES);

  ph_t           ph_r, ph_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic [7:0]    rlen_r, rlen_nxt;
  logic [7:0]    kind_r, kind_nxt;
  logic [CW-1:0] comm_r, comm_nxt;
  logic [CW-1:0] tent_r, tent_nxt;
  logic          have_r, have_nxt;
  logic          skip_r, skip_nxt;

  ard_ctl_t      ctl;
  logic [AW-1:0] wr_addr;
  logic          emit_busy;
  logic          accept;
  logic [7:0]    b;
  logic [7:0]    b_kind;
  logic [7:0]    kind_eff;
  logic [8:0]    cnt_p1;
  logic          fin;
  logic [7:0]    pay;
  logic [SW-1:0] grow;

  assign in_ch.ready = !emit_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign b_kind      = b & KIND_MASK;
  assign kind_eff    = (cnt_r == 8'd0) ? b_kind : kind_r;
  assign cnt_p1      = {1'b0, cnt_r} + 9'd1;
  assign fin         = (cnt_p1 >= {1'b0, rlen_r});
  assign pay         = rlen_r - 8'd1;
  assign grow        = SW'(comm_r) + SW'(pay);
  assign wr_addr     = tent_r[AW-1:0];

  // Record parser: next state for one accepted byte
  always_comb begin
    ph_nxt      = ph_r;
    cnt_nxt     = cnt_r;
    rlen_nxt    = rlen_r;
    kind_nxt    = kind_r;
    comm_nxt    = comm_r;
    tent_nxt    = tent_r;
    have_nxt    = have_r;
    skip_nxt    = skip_r;
    ctl.wr_en   = 1'b0;
    ctl.emit_go = 1'b0;
    if (accept) begin
      if (!skip_r) begin
        case (ph_r)
          PH_A: begin
            if (b == CHR_A) ph_nxt = PH_R;
            else skip_nxt = 1'b1;
          end
          PH_R: begin
            if (b == CHR_R) ph_nxt = PH_CHAN;
            else skip_nxt = 1'b1;
          end
          PH_CHAN: begin
            // error channel and anything unknown drop the transfer
            if (b == CHR_STATUS) begin
              ph_nxt  = PH_STATUS;
              cnt_nxt = 8'd0;
            end else if (b == CHR_DATA) begin
              ph_nxt = PH_LEN;
            end else begin
              skip_nxt = 1'b1;
            end
          end
          PH_LEN: begin
            if (b == 8'd0) begin
              skip_nxt = 1'b1;
            end else begin
              rlen_nxt = b;
              cnt_nxt  = 8'd0;
              tent_nxt = comm_r;
              ph_nxt   = PH_BODY;
            end
          end
          PH_BODY: begin
            if (cnt_r == 8'd0) begin
              kind_nxt = b_kind;
            end else if (kind_r == KIND_DATA) begin
              // tentative append; saturates once the buffer is full
              if (tent_r < MSG_C) begin
                ctl.wr_en = 1'b1;
                tent_nxt  = tent_r + CW'(1);
              end
            end
            cnt_nxt = cnt_p1[7:0];
            if (fin) begin
              ph_nxt = PH_A;
              if (kind_eff == KIND_DATA) begin
                // commit the payload only if it fits whole
                if ((pay != 8'd0) && (grow <= MSG_S)) begin
                  comm_nxt = grow[CW-1:0];
                  have_nxt = 1'b1;
                end
                tent_nxt = comm_nxt;
              end else if (((kind_eff == KIND_END0) || (kind_eff == KIND_END1))
                           && have_r) begin
                ctl.emit_go = 1'b1;
                comm_nxt    = '0;
                tent_nxt    = '0;
                have_nxt    = 1'b0;
                skip_nxt    = 1'b1;
              end
            end
          end
          PH_STATUS: begin
            cnt_nxt = cnt_p1[7:0];
            if (cnt_p1 >= 9'd2) ph_nxt = PH_A;
          end
          default: ph_nxt = PH_A;
        endcase
      end
      // end of transfer drops any unfinished record
      if (in_ch.end_of_transfer) begin
        ph_nxt   = PH_A;
        cnt_nxt  = 8'd0;
        tent_nxt = comm_nxt;
        skip_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_A;
      cnt_r  <= 8'd0;
      rlen_r <= 8'd0;
      kind_r <= 8'd0;
      comm_r <= '0;
      tent_r <= '0;
      have_r <= 1'b0;
      skip_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
      rlen_r <= rlen_nxt;
      kind_r <= kind_nxt;
      comm_r <= comm_nxt;
      tent_r <= tent_nxt;
      have_r <= have_nxt;
      skip_r <= skip_nxt;
    end
  end

  // Message buffer and readout
  ard_msg_buf #(
    .MSG_BYTES (MSG_BYTES),
    .AW        (AW),
    .CW        (CW)
  ) u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .wr_data  (b),
    .emit_len (comm_r),
    .busy     (emit_busy),
    .out_ch   (out_ch)
  );

  `ARD_ASSERT(a_comm_range, comm_r <= MSG_C, "committed length past buffer")
  `ARD_ASSERT_IMP(a_no_take_busy, emit_busy, !in_ch.ready, "request taken during readout")
  `ARD_ASSERT_IMP(a_wr_range, ctl.wr_en, tent_r < MSG_C, "store write past buffer")
  `ARD_ASSERT_NXT(a_emit_clears, ctl.emit_go, (comm_r == '0) && !have_r, "message not cleared")

endmodule
